>>> hw/rtl/horizontal_box_blur_defines.svh
// Assertion macros shared by the horizontal box blur RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef HORIZONTAL_BOX_BLUR_DEFINES_SVH
`define HORIZONTAL_BOX_BLUR_DEFINES_SVH

// Same-cycle implication, off while in reset
`define HBB_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("horizontal_box_blur: same-cycle check failed");

// Next-cycle implication, off while in reset
`define HBB_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("horizontal_box_blur: next-cycle check failed");

`endif

>>> hw/rtl/hbb_pkg.sv
// Types and constants of the horizontal box blur.
// No dependencies; used by hbb_div and horizontal_box_blur.
package hbb_pkg;

  // sample window depth and most results one sample can produce
  localparam int WIN_DEPTH = 5;
  localparam int MAX_RES   = 3;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RADIUS    = 1'b0;
  localparam cfg_idx_t CFG_ROW_WIDTH = 1'b1;

  localparam int CFG_DATA_W = 13;

  typedef logic [1:0]            radius_t;
  typedef logic [CFG_DATA_W-1:0] row_width_t;
  typedef logic [2:0]            tap_cnt_t;   // 1..5 taps
  typedef logic [1:0]            res_cnt_t;   // 0..3 results

endpackage

>>> hw/rtl/hbb_div.sv
// Divides a window sum by its tap count (1 to 5), truncating.
// Uses hbb_pkg; /3 and /5 are exact reciprocal multiplies, /2 and /4 shifts.
module hbb_div import hbb_pkg::*; #(
  parameter int SUM_W = 19
) (
  input  logic [SUM_W-1:0] dividend,
  input  tap_cnt_t         taps,
  output logic [SUM_W-1:0] quotient
);

  // m = ceil(2^(N+3)/d) gives exact floor(x/d) for any N-bit x, d = 3 or 5
  localparam int SHIFT  = SUM_W + 3;
  localparam int PROD_W = SUM_W + SHIFT;
  localparam longint unsigned RECIP3 = ((longint'(1) << SHIFT) + 2) / 3;
  localparam longint unsigned RECIP5 = ((longint'(1) << SHIFT) + 4) / 5;

  logic [SHIFT-1:0]  recip;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  q_mul;

  // one multiplier shared by both odd divisors
  assign recip = (taps == 3'd3) ? SHIFT'(RECIP3) : SHIFT'(RECIP5);
  assign prod  = PROD_W'(dividend) * PROD_W'(recip);
  assign q_mul = prod[PROD_W-1:SHIFT];

  always_comb begin
    case (taps)
      3'd2:    quotient = dividend >> 1;
      3'd3:    quotient = q_mul;
      3'd4:    quotient = dividend >> 2;
      3'd5:    quotient = q_mul;
      default: quotient = dividend;
    endcase
  end

endmodule

>>> hw/rtl/horizontal_box_blur.sv
// Horizontal box blur (3 or 5 taps) over a stream of row samples.
// Uses hbb_pkg, hbb_div and the assertion macros in horizontal_box_blur_defines.svh.
//
// Usage:
//   Samples of a row enter on in_pixel_in, one per transfer (in_valid high,
//   in_stall low at a rising edge), in column order. Blurred samples leave on
//   out_pixel_out in column order, out_row_last marking the final one of a row.
//   The window shrinks at both row edges and the sum is divided by the taps used.
//   Registers (cfg_index/cfg_data, written when cfg_valid and cfg_ready):
//   0 = blur radius, 1 = row width. cfg_ready is always high; write only while
//   the block has no result outstanding.
// Timing:
//   One sample per cycle while in_stall is low. The transfer of the sample that
//   completes a result's window (radius columns later) starts it through the
//   control stage, sum stage and output register, which raises out_valid. The last
//   sample of a row yields radius + 1 results, which leave one per cycle from
//   the sum stage unless out_stall holds them, so the input stalls at each row
//   end. The divide is combinational into the output register; the per-cycle
//   cost is one adder chain or one multiply. With out_valid and out_stall high
//   the output register holds; in_stall rises once the two stages behind it fill.
// Reset: radius 1, row width 640, column 0, no results pending.
`include "horizontal_box_blur_defines.svh"

module horizontal_box_blur import hbb_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int MAX_ROW    = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_pixel_in,
  // blurred output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_pixel_out,
  output logic                  out_row_last,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_ROW);
  localparam int WID_W = COL_W + 1;
  localparam int SUM_W = PIXEL_BITS + 3;

  // configuration
  radius_t    rad_r;
  row_width_t width_r;

  // row state
  logic [PIXEL_BITS-1:0] win_r [WIN_DEPTH];
  logic [COL_W-1:0]      col_r;

  // control stage: result count and window extents of the newest sample
  logic     s1_vld_r;
  res_cnt_t s1_cnt_r;
  logic     s1_last_r;
  tap_cnt_t s1_dmax_r [MAX_RES];

  // sum stage
  logic             s2_vld_r;
  res_cnt_t         s2_cnt_r;
  res_cnt_t         s2_idx_r;
  logic             s2_last_r;
  logic [SUM_W-1:0] s2_sum_r  [MAX_RES];
  tap_cnt_t         s2_taps_r [MAX_RES];

  // output register
  logic        out_vld_r;
  logic [15:0] out_pix_r;
  logic        out_last_r;

  logic                  in_xfer;
  logic [PIXEL_BITS-1:0] pix;
  logic [1:0]            r_eff;
  logic [WID_W-1:0]      w_eff;
  logic                  in_last;
  logic                  k_ge_r;
  logic [1:0]            e_start;
  res_cnt_t              s1_cnt_nxt;
  tap_cnt_t              s1_dmax_nxt [MAX_RES];
  logic [SUM_W-1:0]      pre [WIN_DEPTH];
  logic [SUM_W-1:0]      s2_sum_nxt [MAX_RES];
  logic                  out_ready;
  logic                  s2_final;
  logic                  s2_free;
  logic                  s2_load;
  logic                  s1_free;
  logic [SUM_W-1:0]      div_q;

  // handshakes along the pipeline
  assign out_ready = !out_vld_r || !out_stall;
  assign s2_final  = (s2_idx_r == s2_cnt_r - 2'd1);
  assign s2_free   = !s2_vld_r || (out_ready && s2_final);
  assign s2_load   = s1_vld_r && s2_free && (s1_cnt_r != 2'd0);
  assign s1_free   = !s1_vld_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign pix = in_pixel_in[PIXEL_BITS-1:0];

  // effective radius and row width
  assign r_eff = (rad_r >= 2'd2) ? 2'd2 : 2'd1;

  always_comb begin
    if (width_r < CFG_DATA_W'(4)) begin
      w_eff = WID_W'(4);
    end else if (32'(width_r) > 32'(MAX_ROW)) begin
      w_eff = WID_W'(MAX_ROW);
    end else begin
      w_eff = WID_W'(width_r);
    end
  end

  assign in_last = (WID_W'(col_r) >= w_eff - WID_W'(1));
  assign k_ge_r  = (32'(col_r) >= 32'(r_eff));

  // results for this sample: offsets e = e_start down to 0 behind the newest column
  always_comb begin
    logic [2:0] e_i;
    logic [2:0] reach;
    e_start    = (k_ge_r || !in_last) ? r_eff : 2'(col_r);
    s1_cnt_nxt = in_last ? (e_start + 2'd1) : {1'b0, k_ge_r};
    for (int i = 0; i < MAX_RES; i++) begin
      e_i   = 3'(e_start) - 3'(i);
      reach = e_i + 3'(r_eff);
      s1_dmax_nxt[i] = (32'(col_r) < 32'(reach)) ? 3'(col_r) : reach;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r   <= radius_t'(1);
      width_r <= row_width_t'(640);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIUS:    rad_r   <= cfg_data[1:0];
        CFG_ROW_WIDTH: width_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // sample window shift
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_r[0] <= pix;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // column counter, wraps at the row end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (in_xfer) begin
      col_r <= in_last ? '0 : col_r + COL_W'(1);
    end
  end

  // control stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_free) begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_xfer) begin
      s1_cnt_r  <= s1_cnt_nxt;
      s1_last_r <= in_last;
      for (int i = 0; i < MAX_RES; i++) begin
        s1_dmax_r[i] <= s1_dmax_nxt[i];
      end
    end
  end

  // prefix sums over the window, newest first
  always_comb begin
    pre[0] = SUM_W'(win_r[0]);
    for (int d = 1; d < WIN_DEPTH; d++) begin
      pre[d] = pre[d-1] + SUM_W'(win_r[d]);
    end
    for (int i = 0; i < MAX_RES; i++) begin
      case (s1_dmax_r[i])
        3'd0:    s2_sum_nxt[i] = pre[0];
        3'd1:    s2_sum_nxt[i] = pre[1];
        3'd2:    s2_sum_nxt[i] = pre[2];
        3'd3:    s2_sum_nxt[i] = pre[3];
        default: s2_sum_nxt[i] = pre[4];
      endcase
    end
  end

  // sum stage; results leave one per cycle through idx while out_ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s2_idx_r <= '0;
    end else if (s2_free) begin
      s2_vld_r <= s2_load;
      s2_idx_r <= '0;
    end else if (out_ready) begin
      s2_idx_r <= s2_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_cnt_r  <= s1_cnt_r;
      s2_last_r <= s1_last_r;
      for (int i = 0; i < MAX_RES; i++) begin
        s2_sum_r[i]  <= s2_sum_nxt[i];
        s2_taps_r[i] <= s1_dmax_r[i] + 3'd1;
      end
    end
  end

  // divide the selected sum by its tap count
  hbb_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .dividend(s2_sum_r[s2_idx_r]),
    .taps    (s2_taps_r[s2_idx_r]),
    .quotient(div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ready) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_vld_r) begin
      out_pix_r  <= 16'(div_q);
      out_last_r <= s2_last_r && s2_final;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_pixel_out = out_pix_r;
  assign out_row_last  = out_last_r;

  // checks
  `HBB_CHECK(a_idx_in_range, s2_vld_r, s2_idx_r < s2_cnt_r)
  `HBB_CHECK(a_s2_has_results, s2_vld_r, s2_cnt_r != 2'd0)
  `HBB_CHECK_NEXT(a_row_wrap, in_xfer && in_last, col_r == '0)

endmodule
